// ----- rtl/core/kfd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfd_pkg: shared definitions for the KISS frame decoder
// Byte codes of the framing, result kinds, field widths and the result word.
// ----------------------------------------------------------------------------
package kfd_pkg;

   localparam int MAX_FRAME_DEFAULT = 1024;

   localparam int BYTE_W      = 8;
   localparam int KIND_W      = 2;
   localparam int FRAME_LEN_W = 11;

   // framing bytes
   localparam logic [BYTE_W-1:0] FEND  = 8'hC0;
   localparam logic [BYTE_W-1:0] FESC  = 8'hDB;
   localparam logic [BYTE_W-1:0] TFEND = 8'hDC;
   localparam logic [BYTE_W-1:0] TFESC = 8'hDD;
   localparam logic [BYTE_W-1:0] CMD   = 8'h00;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ABORT = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]      kind;
      logic [BYTE_W-1:0]      data_byte;
      logic [FRAME_LEN_W-1:0] frame_length;
   } result_type;

endpackage

// ----- rtl/core/kfd_in_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfd_in_stage: input word register
// Captures one serial byte per accepted word and holds it until decoded.
// ----------------------------------------------------------------------------
module kfd_in_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [kfd_pkg::BYTE_W-1:0] req_serial_byte,
   input  logic                       advance,
   output logic                       stage_valid,
   output logic [kfd_pkg::BYTE_W-1:0] stage_byte
);

   logic                       valid_ff, valid_in;
   logic [kfd_pkg::BYTE_W-1:0] byte_ff;
   logic                       accept;

   // hold the word while the decoder cannot move it on
   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_serial_byte;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_byte  = byte_ff;

endmodule

// ----- rtl/core/kfd_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfd_decode: KISS framing state and byte decode
// Tracks frame, escape and length state; forms at most one result per byte.
// ----------------------------------------------------------------------------
module kfd_decode #(
   parameter int MAX_FRAME = kfd_pkg::MAX_FRAME_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic [kfd_pkg::BYTE_W-1:0] step_byte,
   output logic                       res_valid,
   output kfd_pkg::result_type        res
);

   localparam int CNT_W = $clog2(MAX_FRAME + 2);
   localparam int EXT_W = (CNT_W > kfd_pkg::FRAME_LEN_W) ? CNT_W : kfd_pkg::FRAME_LEN_W;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME);

   logic             in_frame_ff, in_frame_in;
   logic             saw_end_ff, saw_end_in;
   logic             esc_ff, esc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic [CNT_W-1:0]           cnt_plus;
   logic [EXT_W-1:0]           cnt_ext, cnt_plus_ext;
   logic [kfd_pkg::BYTE_W-1:0] data_byte;

   assign cnt_plus     = cnt_ff + 1'b1;
   assign cnt_ext      = EXT_W'(cnt_ff);
   assign cnt_plus_ext = EXT_W'(cnt_plus);

   // undo the escape on the byte after FESC
   always_comb begin
      data_byte = step_byte;
      if (esc_ff) begin
         if (step_byte == kfd_pkg::TFEND) begin
            data_byte = kfd_pkg::FEND;
         end else if (step_byte == kfd_pkg::TFESC) begin
            data_byte = kfd_pkg::FESC;
         end
      end
   end

   always_comb begin
      in_frame_in = in_frame_ff;
      saw_end_in  = saw_end_ff;
      esc_in      = esc_ff;
      cnt_in      = cnt_ff;
      res_valid   = 1'b0;
      res         = '0;
      if (step) begin
         if (!in_frame_ff) begin
            if (step_byte == kfd_pkg::FEND) begin
               saw_end_in = 1'b1;
            end else if (step_byte == kfd_pkg::CMD && saw_end_ff) begin
               saw_end_in  = 1'b0;
               in_frame_in = 1'b1;
               esc_in      = 1'b0;
               cnt_in      = '0;
            end else begin
               saw_end_in = 1'b0;
            end
         end else if (step_byte == kfd_pkg::FEND) begin
            in_frame_in      = 1'b0;
            saw_end_in       = 1'b0;
            esc_in           = 1'b0;
            cnt_in           = '0;
            res_valid        = 1'b1;
            res.kind         = kfd_pkg::KIND_END;
            res.frame_length = cnt_ext[kfd_pkg::FRAME_LEN_W-1:0];
         end else if (step_byte == kfd_pkg::FESC) begin
            esc_in = 1'b1;
         end else begin
            esc_in    = 1'b0;
            res_valid = 1'b1;
            if (cnt_plus > CNT_MAX) begin
               // drop the byte and abort the frame
               in_frame_in = 1'b0;
               saw_end_in  = 1'b0;
               cnt_in      = '0;
               res.kind    = kfd_pkg::KIND_ABORT;
            end else begin
               cnt_in           = cnt_plus;
               res.kind         = kfd_pkg::KIND_DATA;
               res.data_byte    = data_byte;
               res.frame_length = cnt_plus_ext[kfd_pkg::FRAME_LEN_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         saw_end_ff  <= 1'b0;
         esc_ff      <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         in_frame_ff <= in_frame_in;
         saw_end_ff  <= saw_end_in;
         esc_ff      <= esc_in;
         cnt_ff      <= cnt_in;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_MAX)
      else $error("frame byte count beyond limit");

   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> cnt_ff == '0)
      else $error("byte count nonzero outside a frame");

   a_esc_in_frame: assert property (@(posedge clock) disable iff (reset)
      esc_ff |-> in_frame_ff)
      else $error("escape pending outside a frame");

   a_abort_closes: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.kind == kfd_pkg::KIND_ABORT |=> !in_frame_ff && !saw_end_ff)
      else $error("frame still open after abort");

   a_no_result_outside: assert property (@(posedge clock) disable iff (reset)
      step && !in_frame_ff |-> !res_valid)
      else $error("result produced outside a frame");

endmodule

// ----- rtl/core/kfd_out_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfd_out_stage: result word register
// Holds one result until the receiver takes it; frees when not stalled.
// ----------------------------------------------------------------------------
module kfd_out_stage (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            res_valid,
   input  kfd_pkg::result_type             res,
   output logic                            ready,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [kfd_pkg::KIND_W-1:0]      rsp_kind,
   output logic [kfd_pkg::BYTE_W-1:0]      rsp_data_byte,
   output logic [kfd_pkg::FRAME_LEN_W-1:0] rsp_frame_length
);

   logic                valid_ff;
   kfd_pkg::result_type res_ff;

   assign ready = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready) begin
         valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready && res_valid) begin
         res_ff <= res;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_kind         = res_ff.kind;
   assign rsp_data_byte    = res_ff.data_byte;
   assign rsp_frame_length = res_ff.frame_length;

endmodule

// ----- rtl/core/kiss_frame_decoder_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kiss_frame_decoder_top: KISS framing decoder
// Turns a raw serial byte stream into decoded payload bytes and frame events.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one raw serial byte per word; a word moves when req_valid
//   is high and req_stall is low. rsp_* returns at most one result word per
//   input byte: a decoded data byte with the running length, a frame end
//   with the final length, or an abort when a frame exceeds MAX_FRAME bytes.
//   Bytes outside a frame, FEND/command openers and FESC give no result.
//   Throughput: one byte per cycle while rsp_stall is low; an accepted byte
//   waits in the input register, which feeds the decode logic and the
//   result register directly, and the frame state updates as each byte
//   passes into the result register, which drives rsp_valid.
//   Stall: while rsp_stall holds a full result register, the input register
//   keeps its byte and req_stall rises, so at most two words are in flight.
//   Reset (synchronous, active high) empties both registers and closes any
//   open frame; a new FEND followed by 0x00 is needed to start a frame.
// ----------------------------------------------------------------------------
module kiss_frame_decoder_top #(
   parameter int MAX_FRAME = kfd_pkg::MAX_FRAME_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [kfd_pkg::BYTE_W-1:0]      req_serial_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [kfd_pkg::KIND_W-1:0]      rsp_kind,
   output logic [kfd_pkg::BYTE_W-1:0]      rsp_data_byte,
   output logic [kfd_pkg::FRAME_LEN_W-1:0] rsp_frame_length
);

   logic                       stage_valid;
   logic [kfd_pkg::BYTE_W-1:0] stage_byte;
   logic                       out_ready;
   logic                       step;
   logic                       res_valid;
   kfd_pkg::result_type        res;

   // advance the held byte whenever the result register can take a word
   assign step = stage_valid && out_ready;

   kfd_in_stage u_in_stage (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_serial_byte (req_serial_byte),
      .advance         (out_ready),
      .stage_valid     (stage_valid),
      .stage_byte      (stage_byte)
   );

   // decode the byte and update frame state as it passes through
   kfd_decode #(
      .MAX_FRAME (MAX_FRAME)
   ) u_decode (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .step_byte (stage_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   // hold the result until the receiver drops rsp_stall
   kfd_out_stage u_out_stage (
      .clock            (clock),
      .reset            (reset),
      .res_valid        (res_valid),
      .res              (res),
      .ready            (out_ready),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_frame_length (rsp_frame_length)
   );

endmodule
